FILE: rtl/kmsd_pkg.sv
// Shared constants and types for the key matrix scan and debounce block.
package kmsd_pkg;

    localparam int ROW_COUNT_DEF    = 4;
    localparam int COLUMN_COUNT_DEF = 4;
    localparam int CELL_COUNT_DEF   = 16;

    localparam int TABLE_CELLS = 16;
    localparam int COUNT_W     = 5;
    localparam int DEB_W       = 5;
    localparam int MAP_W       = 64;
    localparam int LOGICAL_W   = 4;
    localparam int ROW_BITS_W  = 4;
    localparam int STATE_W     = 16;
    localparam int FLIP_W      = 32;
    localparam int DRIVE_W     = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;
    localparam int PHYS_W      = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [DEB_W-1:0]   DEB_MIN   = 5'd1;
    localparam logic [DEB_W-1:0]   DEB_MAX   = 5'd16;
    localparam logic [DEB_W-1:0]   DEB_RESET = 5'd4;
    localparam logic [MAP_W-1:0]   MAP_RESET = 64'hFEDC_BA98_7654_3210;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_MAP = 1'b1;

    typedef struct packed {
        logic               value;
        logic [COUNT_W-1:0] count;
    } cell_t;

endpackage

FILE: rtl/key_matrix_scan_debounce.sv
// Key matrix scanner: per-cell debounce state in a column-wide memory.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------------
//  s_      | in        | s_valid/s_ready  | s_row_bits
//  m_      | out       | m_valid/m_ready  | m_any_flipped, m_switch_state,
//          |           |                  | m_flip_total, m_drive_column, m_sweep_done
//  cfg_    | in        | cfg_wr_en        | cfg_index, cfg_wr_data
//
// One column scan per cycle sustained while the output is not stalled. The
// column's cell entry is read from the cell memory at the accepting edge; when
// the update stage fires, the cells, state word and flip counter are updated,
// the entry is written back, the result is loaded and m_valid is raised.
// A write-back to the column read in the same cycle is forwarded.
// Reset marks every column entry invalid (reads as zero); no clearing pass.
// A stalled output holds the update stage, which in turn holds s_ready low.
module key_matrix_scan_debounce #(
    parameter int ROW_COUNT    = kmsd_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kmsd_pkg::COLUMN_COUNT_DEF,
    parameter int CELL_COUNT   = kmsd_pkg::CELL_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kmsd_pkg::ROW_BITS_W-1:0]     s_row_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_any_flipped,
    output logic [kmsd_pkg::STATE_W-1:0]        m_switch_state,
    output logic [kmsd_pkg::FLIP_W-1:0]         m_flip_total,
    output logic [kmsd_pkg::DRIVE_W-1:0]        m_drive_column,
    output logic                                m_sweep_done,
    input  logic                                cfg_wr_en,
    input  logic [kmsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kmsd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import kmsd_pkg::*;

    localparam int COL_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int FLIPS_W = $clog2(ROW_COUNT + 1);

    typedef cell_t [ROW_COUNT-1:0] entry_t;

    // configuration
    logic [DEB_W-1:0] debounce_reg;
    logic [MAP_W-1:0] map_reg;

    // cell memory and per-column valid bits
    entry_t            cell_mem [COLUMN_COUNT];
    logic [COLUMN_COUNT-1:0] col_valid_reg;

    logic [COL_W-1:0]  col_reg;

    // update stage
    logic              st1_valid_reg;
    logic [COL_W-1:0]  st1_col_reg;
    logic [ROW_BITS_W-1:0] st1_rows_reg;
    entry_t            rd_entry_reg;
    logic              rd_hit_reg;
    logic              fwd_reg;
    entry_t            fwd_entry_reg;

    logic [STATE_W-1:0] word_reg;
    logic [FLIP_W-1:0]  flip_reg;

    // output register
    logic               m_valid_reg;
    logic               m_any_flipped_reg;
    logic [STATE_W-1:0] m_switch_state_reg;
    logic [FLIP_W-1:0]  m_flip_total_reg;
    logic [DRIVE_W-1:0] m_drive_column_reg;
    logic               m_sweep_done_reg;

    logic               accept;
    logic               fire;
    logic [DEB_W-1:0]   deb_eff;
    entry_t             cur_entry;
    entry_t             entry_next;
    logic [STATE_W-1:0] word_next;
    logic [FLIPS_W-1:0] flips;
    logic               last_col;
    logic [COL_W-1:0]   next_col;

    assign fire    = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st1_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (debounce_reg < DEB_MIN) begin
            deb_eff = DEB_MIN;
        end else if (debounce_reg > DEB_MAX) begin
            deb_eff = DEB_MAX;
        end else begin
            deb_eff = debounce_reg;
        end
    end

    always_comb begin
        if (fwd_reg) begin
            cur_entry = fwd_entry_reg;
        end else if (rd_hit_reg) begin
            cur_entry = rd_entry_reg;
        end else begin
            cur_entry = '0;
        end
    end

    // cells of the column are applied in row order so shared map targets resolve
    always_comb begin
        logic [PHYS_W-1:0]    phys;
        logic [LOGICAL_W-1:0] logical;
        logic                 sample;
        cell_t                c;
        entry_next = cur_entry;
        word_next  = word_reg;
        flips      = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            phys    = PHYS_W'(int'(st1_col_reg) * ROW_COUNT + r);
            logical = map_reg[{phys[3:0], 2'b00} +: LOGICAL_W];
            sample  = (r < ROW_BITS_W) ? st1_rows_reg[2'(r)] : 1'b0;
            c       = cur_entry[r];
            if ((int'(phys) < CELL_COUNT) && (int'(phys) < TABLE_CELLS)) begin
                if (sample == c.value) begin
                    if (c.count < COUNT_MAX) begin
                        c.count = c.count + 1'b1;
                    end
                end else begin
                    c.value = sample;
                    c.count = COUNT_W'(1);
                end
                if (c.count >= deb_eff) begin
                    if (word_next[logical] != c.value) begin
                        word_next[logical] = c.value;
                        flips = flips + 1'b1;
                    end
                    if (c.count > deb_eff) begin
                        c.count = deb_eff;
                    end
                end
            end
            entry_next[r] = c;
        end
    end

    assign last_col = (st1_col_reg == COL_W'(COLUMN_COUNT - 1));
    assign next_col = last_col ? '0 : st1_col_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEB_RESET;
            map_reg      <= MAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_wr_data[DEB_W-1:0];
                CFG_CELL_MAP: map_reg      <= cfg_wr_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // cell memory: one read port, one write port
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_entry_reg <= cell_mem[col_reg];
        end
        if (fire) begin
            cell_mem[st1_col_reg] <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_col_reg   <= col_reg;
            st1_rows_reg  <= s_row_bits;
            fwd_entry_reg <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            col_valid_reg <= '0;
            st1_valid_reg <= 1'b0;
            rd_hit_reg    <= 1'b0;
            fwd_reg       <= 1'b0;
            word_reg      <= '0;
            flip_reg      <= '0;
        end else begin
            if (fire) begin
                col_valid_reg[st1_col_reg] <= 1'b1;
                word_reg <= word_next;
                flip_reg <= flip_reg + FLIP_W'(flips);
            end
            if (accept) begin
                col_reg    <= (col_reg == COL_W'(COLUMN_COUNT - 1)) ? '0 : col_reg + 1'b1;
                rd_hit_reg <= col_valid_reg[col_reg];
                fwd_reg    <= fire && (st1_col_reg == col_reg);
            end
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (fire) begin
                st1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_any_flipped_reg  <= (flips != '0);
            m_switch_state_reg <= word_next;
            m_flip_total_reg   <= flip_reg + FLIP_W'(flips);
            m_drive_column_reg <= DRIVE_W'(next_col);
            m_sweep_done_reg   <= last_col;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_any_flipped  = m_any_flipped_reg;
    assign m_switch_state = m_switch_state_reg;
    assign m_flip_total   = m_flip_total_reg;
    assign m_drive_column = m_drive_column_reg;
    assign m_sweep_done   = m_sweep_done_reg;

endmodule
